@@ rtl/core/hsfd_pkg.sv @@
// Shared types, constants and CRC function for the humidity sensor frame decoder.
package hsfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic signed [11:0] HEAT_OFFSET_RESET = 12'sd400;

  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int OFF_W  = 12;

  // byte positions within the frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_humidity;
    logic        crc_error;
  } frame_rec_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/hsfd_ifs.sv @@
// Handshake channel interfaces: frame bytes in, decoded results out, offset writes.
interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;
  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface hsfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temp_cdeg;
  logic        [13:0] rh_cpct;
  logic               crc_error;
  modport source (output valid, output temp_cdeg, output rh_cpct,
                  output crc_error, input ready);
  modport sink   (input valid, input temp_cdeg, input rh_cpct,
                  input crc_error, output ready);
endinterface

interface hsfd_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/humidity_sensor_frame_decoder.sv @@
// Top level of the temperature and humidity sensor frame decoder.
//
// frame: one word per frame byte, frame_start marks the first byte of a frame.
//   Six bytes make a frame: temperature MSB, LSB, CRC-8, humidity MSB, LSB, CRC-8.
//   A byte with frame_start drops any partial frame; after the sixth byte the
//   next byte begins a new frame.
// result: one word per completed frame with the compensated temperature
//   (hundredths of a degree C), humidity (hundredths of a percent) and a CRC
//   error flag. A word with a bad CRC is still delivered.
// cfg: writes the signed board heat offset; always ready. Write only while idle.
// The result word passes through the frame register, the multiply stage and
//   the result register after its sixth byte is accepted.
// Throughput: one byte per cycle unless stalled; the three-stage pipeline
//   advances as a whole. A stalled result holds the pipeline; frame.ready
//   drops only while a result waits and result.ready is low.
// Reset: synchronous, clears byte position, CRC and pipeline valids, and sets
//   the heat offset to 400.
module humidity_sensor_frame_decoder (
  input  logic     clk,
  input  logic     rst,
  hsfd_in_if.sink  frame,
  hsfd_out_if.source result,
  hsfd_cfg_if.sink cfg
);
  import hsfd_pkg::*;

  logic                    advance;
  logic                    accept;
  logic                    rec_valid;
  frame_rec_t              rec;
  logic signed [OFF_W-1:0] heat_offset;

  assign advance     = !result.valid || result.ready;
  assign accept      = frame.valid && advance;
  assign frame.ready = advance;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_offset <= HEAT_OFFSET_RESET;
    end else if (cfg.valid) begin
      heat_offset <= cfg.data;
    end
  end

  hsfd_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .accept      (accept),
    .frame_byte  (frame.frame_byte),
    .frame_start (frame.frame_start),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  hsfd_convert u_convert (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .rec_valid     (rec_valid),
    .rec           (rec),
    .heat_offset   (heat_offset),
    .res_valid     (result.valid),
    .temperature   (result.temp_cdeg),
    .humidity      (result.rh_cpct),
    .res_crc_error (result.crc_error)
  );

endmodule

@@ rtl/core/hsfd_framer.sv @@
// Byte position tracking, CRC checking and raw value capture; registers one record per frame.
module hsfd_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               accept,
  input  logic [7:0]         frame_byte,
  input  logic               frame_start,
  output logic               rec_valid,
  output hsfd_pkg::frame_rec_t rec
);
  import hsfd_pkg::*;

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] raw_temperature, raw_temperature_next;
  logic [15:0] raw_humidity, raw_humidity_next;
  logic        checksum_failed, checksum_failed_next;
  logic [2:0]  pos;
  logic [7:0]  crc_base;
  logic        fail_base;
  logic        emit;

  always_comb begin
    pos = (frame_start || byte_position > POS_H_CRC) ? POS_T_MSB : byte_position;
    crc_base  = (pos == POS_T_MSB) ? CRC_INIT : running_crc;
    fail_base = (pos == POS_T_MSB) ? 1'b0 : checksum_failed;
    raw_temperature_next = raw_temperature;
    raw_humidity_next    = raw_humidity;
    running_crc_next     = crc_base;
    checksum_failed_next = fail_base;
    byte_position_next   = pos + 3'd1;
    emit = 1'b0;
    unique case (pos)
      POS_T_MSB: begin
        raw_temperature_next = {frame_byte, 8'h00};
        running_crc_next     = crc8_byte(crc_base, frame_byte);
      end
      POS_T_LSB: begin
        raw_temperature_next = raw_temperature | {8'h00, frame_byte};
        running_crc_next     = crc8_byte(crc_base, frame_byte);
      end
      POS_T_CRC: begin
        checksum_failed_next = fail_base | (crc_base != frame_byte);
        running_crc_next     = CRC_INIT;
      end
      POS_H_MSB: begin
        raw_humidity_next = {frame_byte, 8'h00};
        running_crc_next  = crc8_byte(crc_base, frame_byte);
      end
      POS_H_LSB: begin
        raw_humidity_next = raw_humidity | {8'h00, frame_byte};
        running_crc_next  = crc8_byte(crc_base, frame_byte);
      end
      default: begin
        checksum_failed_next = fail_base | (crc_base != frame_byte);
        running_crc_next     = CRC_INIT;
        byte_position_next   = POS_T_MSB;
        emit = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_T_MSB;
      running_crc     <= CRC_INIT;
      raw_temperature <= '0;
      raw_humidity    <= '0;
      checksum_failed <= 1'b0;
      rec_valid       <= 1'b0;
    end else begin
      if (accept) begin
        byte_position   <= byte_position_next;
        running_crc     <= running_crc_next;
        raw_temperature <= raw_temperature_next;
        raw_humidity    <= raw_humidity_next;
        checksum_failed <= checksum_failed_next;
      end
      if (advance) begin
        rec_valid <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept && emit) begin
      rec.raw_temperature <= raw_temperature_next;
      rec.raw_humidity    <= raw_humidity_next;
      rec.crc_error       <= checksum_failed_next;
    end
  end

endmodule

@@ rtl/core/hsfd_convert.sv @@
// Two-stage scaling of raw values: multiply, then round, offset and clamp into the result register.
module hsfd_convert (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 rec_valid,
  input  hsfd_pkg::frame_rec_t rec,
  input  logic signed [hsfd_pkg::OFF_W-1:0] heat_offset,
  output logic                 res_valid,
  output logic signed [hsfd_pkg::TEMP_W-1:0] temperature,
  output logic [hsfd_pkg::HUM_W-1:0]         humidity,
  output logic                 res_crc_error
);
  import hsfd_pkg::*;

  localparam logic [30:0]        TEMP_SCALE = 31'd17500;
  localparam logic [29:0]        HUM_SCALE  = 30'd10000;
  localparam logic [30:0]        ROUND_T    = 31'd32768;
  localparam logic [29:0]        ROUND_H    = 30'd32768;
  localparam logic signed [16:0] TEMP_BIAS  = -17'sd4500;
  localparam logic signed [16:0] TEMP_MIN   = -17'sd6500;
  localparam logic signed [16:0] TEMP_MAX   = 17'sd14999;
  localparam logic [13:0]        HUM_MAX    = 14'd10000;

  logic [30:0] prod_t;
  logic [29:0] prod_h;
  logic        prod_valid;
  logic        prod_crc_error;

  logic [30:0]        sum_t;
  logic [29:0]        sum_h;
  logic signed [16:0] t_wide;
  logic signed [16:0] t_clamped;
  logic [13:0]        h_q;

  always_comb begin
    sum_t  = prod_t + ROUND_T;
    sum_h  = prod_h + ROUND_H;
    t_wide = $signed({2'b00, sum_t[30:16]}) + TEMP_BIAS - 17'(heat_offset);
    if (t_wide < TEMP_MIN) begin
      t_clamped = TEMP_MIN;
    end else if (t_wide > TEMP_MAX) begin
      t_clamped = TEMP_MAX;
    end else begin
      t_clamped = t_wide;
    end
    h_q = (sum_h[29:16] > HUM_MAX) ? HUM_MAX : sum_h[29:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else if (advance) begin
      prod_valid <= rec_valid;
      res_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_t         <= 31'(rec.raw_temperature) * TEMP_SCALE;
      prod_h         <= 30'(rec.raw_humidity) * HUM_SCALE;
      prod_crc_error <= rec.crc_error;
      temperature    <= t_clamped[TEMP_W-1:0];
      humidity       <= h_q;
      res_crc_error  <= prod_crc_error;
    end
  end

endmodule

@@ rtl/core/hsfd_checker.sv @@
// Port-level assertions for the frame decoder, bound to the top level.
module hsfd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [14:0] temperature,
  input logic [13:0]        humidity,
  input logic               crc_error
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("frame not ready with empty output");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature) && $stable(humidity)
      && $stable(crc_error))
    else $error("stalled result changed");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity <= 14'd10000)
    else $error("humidity above clamp");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temperature >= -15'sd6500) && (temperature <= 15'sd14999))
    else $error("temperature out of range");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (frame.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .temperature (result.temp_cdeg),
  .humidity    (result.rh_cpct),
  .crc_error   (result.crc_error)
);
